[src/brfo_pkg.sv]
// ----------------------------------------------------------------------------
// brfo_pkg
// Shared constants and types for the byte ring FIFO with overwrite.
// ----------------------------------------------------------------------------
package brfo_pkg;

    localparam int DEPTH       = 64;
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W      = 8;
    localparam int COUNT_W     = 6;
    localparam int REMAINING_W = 7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [PTR_W-1:0] t_ptr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_cmd;

    // Advance a slot pointer with wrap at DEPTH.
    function automatic t_ptr next_slot(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

endpackage

[src/brfo_ctrl.sv]
// ----------------------------------------------------------------------------
// brfo_ctrl
// Sequencer that takes one word, runs it through the datapath and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module brfo_ctrl
    import brfo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_take;
    logic   w_out_free;
    logic   w_in_accept;

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign w_in_accept = i_valid && (r_state == S_IDLE);
    assign w_out_take  = r_out_valid && !i_stall;
    assign w_out_free  = !r_out_valid || w_out_take;

    always_comb begin
        o_cmd.load_in  = w_in_accept;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.load_out = (r_state == S_RESULT) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // The result register is never overwritten while it still holds a word.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_stall))
        else $error("result register loaded while occupied");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == S_EXEC))
        else $error("accepted word did not start execution");

    a_exec_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_RESULT))
        else $error("execution did not proceed to result");

endmodule

[src/brfo_dp.sv]
// ----------------------------------------------------------------------------
// brfo_dp
// Datapath: byte store, head and tail pointers, and the result register.
// ----------------------------------------------------------------------------
module brfo_dp
    import brfo_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_op,
    input  logic [DATA_W-1:0]      i_data_in,
    input  logic                   i_overwrite,
    output logic                   o_write_accepted,
    output logic [DATA_W-1:0]      o_read_data,
    output logic                   o_read_valid,
    output logic [COUNT_W-1:0]     o_count,
    output logic [REMAINING_W-1:0] o_remaining
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Latched input word.
    logic              r_op;
    logic [DATA_W-1:0] r_data;
    logic              r_ow;

    t_ptr r_head, n_head;
    t_ptr r_tail, n_tail;

    // Step outcome.
    logic              r_acc;
    logic              r_rvalid;
    t_ptr              r_cnt;
    logic [DATA_W-1:0] r_mem_q;

    // Result register.
    logic                   r_o_acc;
    logic [DATA_W-1:0]      r_o_data;
    logic                   r_o_rvalid;
    logic [COUNT_W-1:0]     r_o_count;
    logic [REMAINING_W-1:0] r_o_remaining;

    t_ptr w_head_nx;
    t_ptr w_tail_nx;
    logic w_full;
    logic w_empty;
    logic w_write_ok;
    logic w_read_ok;
    t_ptr w_cnt;
    logic [PTR_W:0] w_remaining;

    assign w_head_nx  = next_slot(r_head);
    assign w_tail_nx  = next_slot(r_tail);
    assign w_full     = (w_head_nx == r_tail);
    assign w_empty    = (r_head == r_tail);
    assign w_write_ok = (r_op == OP_WRITE) && (r_ow || !w_full);
    assign w_read_ok  = (r_op == OP_READ) && !w_empty;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (w_write_ok) begin
            n_head = w_head_nx;
            // An overwriting write into a full buffer pushes out the oldest byte.
            if (w_full) begin
                n_tail = w_tail_nx;
            end
        end
        if (w_read_ok) begin
            n_tail = w_tail_nx;
        end
        if (n_head >= n_tail) begin
            w_cnt = n_head - n_tail;
        end else begin
            w_cnt = t_ptr'((PTR_W + 1)'(DEPTH) + {1'b0, n_head} - {1'b0, n_tail});
        end
        w_remaining = (PTR_W + 1)'(DEPTH) - {1'b0, r_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_write_ok) begin
            r_mem[r_head] <= r_data;
        end
        if (i_cmd.exec) begin
            r_mem_q <= r_mem[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_op;
            r_data <= i_data_in;
            r_ow   <= i_overwrite;
        end
        if (i_cmd.exec) begin
            r_acc    <= w_write_ok;
            r_rvalid <= w_read_ok;
            r_cnt    <= w_cnt;
        end
        if (i_cmd.load_out) begin
            r_o_acc       <= r_acc;
            r_o_data      <= r_rvalid ? r_mem_q : '0;
            r_o_rvalid    <= r_rvalid;
            r_o_count     <= COUNT_W'(r_cnt);
            r_o_remaining <= REMAINING_W'(w_remaining);
        end
    end

    assign o_write_accepted = r_o_acc;
    assign o_read_data      = r_o_data;
    assign o_read_valid     = r_o_rvalid;
    assign o_count          = r_o_count;
    assign o_remaining      = r_o_remaining;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= t_ptr'(DEPTH - 1)) && (r_tail <= t_ptr'(DEPTH - 1)))
        else $error("pointer out of range");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_WRITE) && !w_write_ok) |=>
            ($stable(r_head) && $stable(r_tail)))
        else $error("refused write moved a pointer");

    a_empty_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_READ) && w_empty) |=>
            ($stable(r_head) && $stable(r_tail) && !r_rvalid))
        else $error("read of empty buffer changed state");

endmodule

[src/byte_ring_fifo_overwrite_unit.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_overwrite_unit
// Byte ring FIFO with one spare slot and an optional overwrite on full.
// ----------------------------------------------------------------------------
//  Channel   Valid      Stall      Payload
//  input     i_valid    o_stall    i_op, i_data_in, i_overwrite
//  output    o_valid    i_stall    o_write_accepted, o_read_data, o_read_valid,
//                                  o_count, o_remaining
//
// Each word passes through three controller steps: latch, one store access (write
// or registered read), then load of the result register. A new word is taken only
// once the last step of the previous word is done, so words never overlap. A stalled
// result holds the word in the last step until the result register frees. Reset
// is synchronous and empties the buffer at once.
// ----------------------------------------------------------------------------
module byte_ring_fifo_overwrite_unit
    import brfo_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_op,
    input  logic [DATA_W-1:0]      i_data_in,
    input  logic                   i_overwrite,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_write_accepted,
    output logic [DATA_W-1:0]      o_read_data,
    output logic                   o_read_valid,
    output logic [COUNT_W-1:0]     o_count,
    output logic [REMAINING_W-1:0] o_remaining
);

    t_cmd w_cmd;

    brfo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    brfo_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_op             (i_op),
        .i_data_in        (i_data_in),
        .i_overwrite      (i_overwrite),
        .o_write_accepted (o_write_accepted),
        .o_read_data      (o_read_data),
        .o_read_valid     (o_read_valid),
        .o_count          (o_count),
        .o_remaining      (o_remaining)
    );

endmodule
